// ===== hdl/assert_macros.svh =====
// Assertion macros used by the shortest-seek ordering datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ssf_pkg.sv =====
// Package: constants, controller states and control/status structs for the SSF order block.
package ssf_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int TRACK_BITS_DEF  = 8;
    localparam int PORT_TRACK_W    = 8;
    localparam int DIST_W          = 14;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_HEAD_RD,
        ST_HEAD_CAP,
        ST_SCAN,
        ST_OUT
    } ctl_state_t;

    typedef struct packed {
        logic load;
        logic head_rd;
        logic head_cap;
        logic scan;
        logic commit;
        logic batch_clr;
    } ssf_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic final_flag;
    } ssf_sts_t;

endpackage

// ===== hdl/ssf_ctrl.sv =====
// Controller state machine: load, head fetch, nearest-track scan and result handoff.
module ssf_ctrl
    import ssf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     last,
    output logic     req_stall,
    output logic     res_valid,
    input  logic     res_stall,
    input  ssf_sts_t sts,
    output ssf_cmd_t cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (req_valid && last)
                begin
                    state_next = ST_HEAD_RD;
                end
            end
            ST_HEAD_RD:
            begin
                state_next = ST_HEAD_CAP;
            end
            ST_HEAD_CAP:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!res_stall)
                begin
                    state_next = sts.final_flag ? ST_LOAD : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        res_valid = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                req_stall = 1'b0;
                cmd.load  = req_valid;
            end
            ST_HEAD_RD:
            begin
                cmd.head_rd = 1'b1;
            end
            ST_HEAD_CAP:
            begin
                cmd.head_cap = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_OUT:
            begin
                res_valid     = 1'b1;
                cmd.batch_clr = !res_stall && sts.final_flag;
                cmd.commit    = !res_stall && !sts.final_flag;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/ssf_datapath.sv =====
// Datapath: request store, pending bits, nearest-track search and running seek distance.
`include "assert_macros.svh"

module ssf_datapath
    import ssf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TRACK_BITS  = TRACK_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ssf_cmd_t                cmd,
    output ssf_sts_t                sts,
    input  logic [PORT_TRACK_W-1:0] track,
    output logic [PORT_TRACK_W-1:0] served_track,
    output logic [DIST_W-1:0]       total_distance
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int EXT_W = (TRACK_BITS > PORT_TRACK_W) ? TRACK_BITS : PORT_TRACK_W;
    localparam int SUM_W = ((TRACK_BITS > DIST_W) ? TRACK_BITS : DIST_W) + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    logic [TRACK_BITS-1:0] mem [QUEUE_DEPTH];
    logic [TRACK_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]      rd_addr;

    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [QUEUE_DEPTH-1:0] pending_reg, pending_next;
    logic [TRACK_BITS-1:0]  head_reg, head_next;
    logic [TRACK_BITS-1:0]  out_track_reg, out_track_next;
    logic [DIST_W-1:0]      out_sum_reg, out_sum_next;
    logic [CNT_W-1:0]       res_cnt_reg, res_cnt_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   p_valid_reg, p_valid_next;
    logic [IDX_W-1:0]       p_idx_reg, p_idx_next;
    logic                   found_reg, found_next;
    logic [TRACK_BITS-1:0]  best_val_reg, best_val_next;
    logic [TRACK_BITS-1:0]  best_dist_reg, best_dist_next;
    logic                   clr_en_reg, clr_en_next;

    logic [EXT_W-1:0]      trk_ext;
    logic [TRACK_BITS-1:0] trk_in;
    logic [EXT_W-1:0]      out_ext;
    logic                  store_wr;
    logic                  issue;
    logic [TRACK_BITS-1:0] cand_dist;
    logic                  cand_ok;
    logic                  cand_better;
    logic [SUM_W-1:0]      sum_wide;
    logic [DIST_W-1:0]     sum_sat;

    assign trk_ext        = EXT_W'(track);
    assign trk_in         = trk_ext[TRACK_BITS-1:0];
    assign out_ext        = EXT_W'(out_track_reg);
    assign served_track   = out_ext[PORT_TRACK_W-1:0];
    assign total_distance = out_sum_reg;

    assign store_wr = cmd.load && (cnt_reg < DEPTH_C);
    assign issue    = cmd.scan && (idx_reg < cnt_reg);
    assign rd_addr  = cmd.head_rd ? '0 : idx_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            mem[cnt_reg[IDX_W-1:0]] <= trk_in;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign cand_dist   = (rd_data_reg > head_reg) ? (rd_data_reg - head_reg)
                                                  : (head_reg - rd_data_reg);
    assign cand_ok     = p_valid_reg && pending_reg[p_idx_reg] && (rd_data_reg != head_reg);
    assign cand_better = cand_ok && (!found_reg || (cand_dist < best_dist_reg));

    assign sum_wide = SUM_W'(out_sum_reg) + SUM_W'(best_dist_reg);
    assign sum_sat  = (sum_wide > SUM_W'(DIST_MAX)) ? DIST_MAX : sum_wide[DIST_W-1:0];

    assign sts.scan_done  = !(idx_reg < cnt_reg) && !p_valid_reg;
    assign sts.final_flag = !found_reg || (res_cnt_reg >= DEPTH_C);

    always_comb
    begin
        cnt_next       = cnt_reg;
        pending_next   = pending_reg;
        head_next      = head_reg;
        out_track_next = out_track_reg;
        out_sum_next   = out_sum_reg;
        res_cnt_next   = res_cnt_reg;
        idx_next       = idx_reg;
        p_valid_next   = issue;
        p_idx_next     = idx_reg[IDX_W-1:0];
        found_next     = found_reg;
        best_val_next  = best_val_reg;
        best_dist_next = best_dist_reg;
        clr_en_next    = clr_en_reg;

        if (store_wr)
        begin
            pending_next[cnt_reg[IDX_W-1:0]] = (cnt_reg != '0);
            cnt_next = cnt_reg + 1'b1;
        end

        if (issue)
        begin
            idx_next = idx_reg + 1'b1;
        end

        // chosen value is dropped with its duplicates while the next search runs
        if (p_valid_reg && clr_en_reg && (rd_data_reg == head_reg))
        begin
            pending_next[p_idx_reg] = 1'b0;
        end

        if (cand_better)
        begin
            found_next     = 1'b1;
            best_val_next  = rd_data_reg;
            best_dist_next = cand_dist;
        end

        if (cmd.head_cap)
        begin
            head_next      = rd_data_reg;
            out_track_next = rd_data_reg;
            out_sum_next   = '0;
            res_cnt_next   = CNT_W'(1);
            idx_next       = CNT_W'(1);
            found_next     = 1'b0;
            clr_en_next    = 1'b0;
        end

        if (cmd.commit)
        begin
            head_next      = best_val_reg;
            out_track_next = best_val_reg;
            out_sum_next   = sum_sat;
            res_cnt_next   = res_cnt_reg + 1'b1;
            idx_next       = CNT_W'(1);
            found_next     = 1'b0;
            clr_en_next    = 1'b1;
        end

        if (cmd.batch_clr)
        begin
            cnt_next     = '0;
            pending_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            pending_reg <= '0;
            head_reg    <= '0;
            res_cnt_reg <= '0;
            idx_reg     <= '0;
            p_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
            clr_en_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            pending_reg <= pending_next;
            head_reg    <= head_next;
            res_cnt_reg <= res_cnt_next;
            idx_reg     <= idx_next;
            p_valid_reg <= p_valid_next;
            found_reg   <= found_next;
            clr_en_reg  <= clr_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_track_reg <= out_track_next;
        out_sum_reg   <= out_sum_next;
        p_idx_reg     <= p_idx_next;
        best_val_reg  <= best_val_next;
        best_dist_reg <= best_dist_next;
    end

    `CHK_IMPLY(a_scan_in_range, p_valid_reg, CNT_W'(p_idx_reg) < cnt_reg,
        "scan reads past loaded entries")
    `CHK_IMPLY(a_commit_found, cmd.commit, found_reg, "commit without a candidate")
    `CHK_NEXT(a_head_moves, cmd.commit, head_reg != $past(head_reg),
        "pick did not move the head")
    `CHK_NEXT(a_batch_cleared, cmd.batch_clr, (cnt_reg == '0) && (pending_reg == '0),
        "batch not cleared at end of run")

endmodule

// ===== hdl/shortest_seek_first_order.sv =====
// Top level: shortest-seek-first ordering of a batch of track requests.
//
// Request channel (req_valid/req_stall, track, last): one word per request.
// The first word of a batch is the starting head; words are taken one per
// cycle while loading. The word with last set starts scheduling; words past
// QUEUE_DEPTH are dropped, and req_stall stays high until the run is done.
// Result channel (res_valid/res_stall): the head first, then the nearest
// pending track each time, with the running seek distance (saturating) and
// final_res on the last word of the run.
// After the last request the head is read and captured from the store; every
// result word, the head included, then waits on a search pass over the
// request store through its single read port, and the next pass begins once
// the receiver has taken the word.
// A stalled result holds its value and the search waits behind it.
// Reset clears the batch and pending bits; the store itself is not cleared.
module shortest_seek_first_order
    import ssf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TRACK_BITS  = TRACK_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  logic [PORT_TRACK_W-1:0] track,
    input  logic                    last,
    output logic                    res_valid,
    input  logic                    res_stall,
    output logic [PORT_TRACK_W-1:0] served_track,
    output logic [DIST_W-1:0]       total_distance,
    output logic                    final_res
);

    ssf_cmd_t cmd;
    ssf_sts_t sts;

    assign final_res = sts.final_flag;

    ssf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .last      (last),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ssf_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TRACK_BITS  (TRACK_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .track          (track),
        .served_track   (served_track),
        .total_distance (total_distance)
    );

endmodule
